FILE: sv/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication check, clocked, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/fpskt_pkg.sv
// ----------------------------------------------------------------------------
// fpskt_pkg
// Shared codes and the key fingerprint function of the slot key table.
// ----------------------------------------------------------------------------
package fpskt_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef logic [63:0] word_t;

  // One hash round per call; the sequencer steps it through six rounds.
  function automatic word_t hash_round(input logic [2:0] rnd, input word_t h, input word_t k);
    word_t r;
    r = h;
    case (rnd)
      3'd0: r = (~k) + (k << 18);
      3'd1: r = h ^ (h >> 31);
      3'd2: r = h + (h << 2) + (h << 4);
      3'd3: r = h ^ (h >> 11);
      3'd4: r = h + (h << 6);
      3'd5: r = h ^ (h >> 22);
      default: r = h;
    endcase
    return r;
  endfunction
endpackage

FILE: sv/fpskt_ram.sv
// ----------------------------------------------------------------------------
// fpskt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module fpskt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/fingerprint_slot_key_table_top.sv
// ----------------------------------------------------------------------------
// fingerprint_slot_key_table_top
// Fingerprinted key/value slot table with insert, update, remove and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on in_* carry one request: in_tdata = {value_in, key, op}.
//   Output beats on out_* carry one result: status, slot, value, count.
//   Each request yields exactly one output beat.
// Sequence:
//   Hash rounds run in one shared shift/add/xor unit, then a scan of the
//   slots: a free slot is passed over in S_SCAN, a valid one goes through
//   S_CMP (registered read of its fingerprint and key, then compare). The
//   scan stops at the first hit. S_DONE then writes and closes; a lookup
//   hit adds S_READ to read the value.
//   in_tready is high only while the sequencer is idle and the output
//   register is empty, so a new request is taken only after the previous
//   result has left the output register.
// Reset:
//   rst_n low clears all valid bits, the count and the sequencer. Key, value
//   and fingerprint stores are not cleared; they are read only for valid slots.
// Stall:
//   Hold a result in the output register until out_tready; take no request
//   meanwhile.
// ----------------------------------------------------------------------------
module fingerprint_slot_key_table_top #(
  parameter int SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[1:0], key[65:2], value_in[129:66], zero fill to 136
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], slot[7:2], value_out[71:8], entry_count[78:72], zero fill
  output logic [79:0]  out_tdata
);
  import fpskt_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_READ = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       op_r;
  word_t            key_r, val_r, h_r;
  logic [2:0]       rnd_r;
  logic [AW:0]      idx_r;
  logic [SLOTS-1:0] valid_r;
  logic [CW-1:0]    count_r;
  logic             hit_r;
  logic [AW-1:0]    hit_idx_r;
  logic             ov_r;
  logic [79:0]      od_r;

  // Key, value and fingerprint memories.
  logic          kwe, vwe;
  logic [AW-1:0] waddr, raddr;
  word_t         krd, vrd;
  logic [7:0]    fprd;
  logic [7:0]    fp;

  fpskt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (
    .clk(clk), .we(kwe), .waddr(waddr), .wdata(key_r), .raddr(raddr), .rdata(krd)
  );
  fpskt_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_vals (
    .clk(clk), .we(vwe), .waddr(waddr), .wdata(val_r), .raddr(raddr), .rdata(vrd)
  );
  fpskt_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_fps (
    .clk(clk), .we(kwe), .waddr(waddr), .wdata(fp), .raddr(raddr), .rdata(fprd)
  );

  // Lowest free slot: priority search over the valid bitmap.
  logic          free_any;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic [AW-1:0] cur;
  logic          cand;
  logic          key_match;
  assign fp   = h_r[7:0];
  assign cur  = idx_r[AW-1:0];
  assign cand = valid_r[cur];
  // Fingerprint filter and full key compare on the registered read data.
  assign key_match = (fprd == fp) && (krd == key_r);
  assign raddr = (state_r == S_DONE || state_r == S_READ) ? hit_idx_r : cur;
  assign in_tready = (state_r == S_IDLE) && !ov_r;

  logic do_ins, do_upd, do_rem;
  assign do_ins = (state_r == S_DONE) && (op_r == OP_INSERT) && !hit_r && free_any;
  assign do_upd = (state_r == S_DONE) && (op_r == OP_UPDATE) && hit_r;
  assign do_rem = (state_r == S_DONE) && (op_r == OP_REMOVE) && hit_r;
  assign kwe   = do_ins;
  assign vwe   = do_ins || do_upd;
  assign waddr = do_ins ? free_idx : hit_idx_r;

  // Result beat assembled from the outcome of the scan.
  logic [1:0]    res_st;
  logic [AW-1:0] res_slot;
  logic [CW-1:0] res_cnt;
  logic [79:0]   od_nxt;
  always_comb begin
    res_st   = ST_OK;
    res_slot = hit_idx_r;
    res_cnt  = count_r;
    if (op_r == OP_INSERT) begin
      if (hit_r) begin
        res_st = ST_PRESENT;
      end else if (!free_any) begin
        res_st = ST_FULL;
      end else begin
        res_slot = free_idx;
        res_cnt  = count_r + 1'b1;
      end
    end else if (!hit_r) begin
      res_st = ST_ABSENT;
    end else if (op_r == OP_REMOVE) begin
      res_cnt = count_r - 1'b1;
    end
    od_nxt        = '0;
    od_nxt[1:0]   = res_st;
    if (res_st == ST_OK) od_nxt[7:2] = 6'(res_slot);
    if (state_r == S_READ) od_nxt[71:8] = vrd;
    od_nxt[78:72] = 7'(res_cnt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_HASH;
      S_HASH: if (rnd_r == 3'd5) state_nxt = S_SCAN;
      S_SCAN: begin
        if (idx_r == (AW+1)'(SLOTS)) state_nxt = S_DONE;
        else if (cand) state_nxt = S_CMP;
      end
      S_CMP:  state_nxt = key_match ? S_DONE : S_SCAN;
      S_DONE: state_nxt = (op_r == OP_LOOKUP && hit_r) ? S_READ : S_IDLE;
      S_READ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_tvalid && out_tready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r  <= in_tdata[1:0];
            key_r <= in_tdata[65:2];
            val_r <= in_tdata[129:66];
            rnd_r <= 3'd0;
            idx_r <= '0;
            hit_r <= 1'b0;
          end
        end
        S_HASH: begin
          h_r   <= hash_round(rnd_r, h_r, key_r);
          rnd_r <= rnd_r + 3'd1;
        end
        S_SCAN: begin
          if (idx_r != (AW+1)'(SLOTS) && !cand) idx_r <= idx_r + 1'b1;
        end
        S_CMP: begin
          if (key_match) begin
            hit_r     <= 1'b1;
            hit_idx_r <= cur;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!(op_r == OP_LOOKUP && hit_r)) begin
            ov_r <= 1'b1;
            od_r <= od_nxt;
          end
          if (do_ins) begin
            valid_r[free_idx] <= 1'b1;
          end else if (do_rem) begin
            valid_r[hit_idx_r] <= 1'b0;
          end
          count_r <= res_cnt;
        end
        S_READ: begin
          ov_r <= 1'b1;
          od_r <= od_nxt;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule

FILE: sv/fpskt_checker.sv
// ----------------------------------------------------------------------------
// fpskt_checker
// Port-level checks of the slot key table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fpskt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [79:0]  out_tdata
);
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "accepted twice")
  `ASSERT_IMPL(a_no_take_while_full, clk, rst_n, out_tvalid, !in_tready, "input taken over result")
  `ASSERT_IMPL(a_slot_zero_on_fail, clk, rst_n, out_tvalid && out_tdata[1:0] != 2'd0,
    out_tdata[71:2] == 70'd0, "slot or value on failure")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")
endmodule

bind fingerprint_slot_key_table_top fpskt_checker u_fpskt_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
